>>> src/wma_pkg.sv
// wma_pkg: request types, controller state encoding and command/status
// structs shared by the moving-average controller, datapath and top level
// no dependencies
package wma_pkg;

  localparam int SAMPLE_W = 8;
  localparam int MEAN_W   = 8;
  localparam int CFG_W    = 7;

  // window length after reset
  localparam logic [CFG_W-1:0] WINDOW_RST = 7'd64;

  // mode codes
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // input request payload
  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
  } in_req_t;

  // result request payload
  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic              cycle_complete;
  } out_req_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_APPLY,
    ST_DIVIDE,
    ST_DONE
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_in;
    logic mem_rd;
    logic apply;
    logic div_step;
    logic out_load;
    logic cfg_wr;
  } wma_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
  } wma_sts_t;

endpackage

>>> src/windowed_moving_average.sv
// windowed_moving_average: top level, joins the controller and the datapath
// depends on wma_pkg, wma_ctrl, wma_datapath
//
// Moving average over the last window_length byte samples. Each input request
// either adds a sample (overwriting the oldest once the window is full) or
// replaces the most recent one, and answers with the truncated mean of the
// stored samples plus a flag when an add wraps the ring back to the start.
// One request is worked at a time: from acceptance it passes one ring read,
// one update of sum, count and ring, eight steps of the radix-2 divider
// (one quotient bit each) and a load of the result register, which waits
// while a stalled result still holds that register. A new request is taken
// once the load is done, also while the previous result still waits
// downstream. The window register is written through the cfg port while no
// request is in flight; any write clears the average. The ring needs no
// clearing after reset.
module windowed_moving_average #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  wma_pkg::in_req_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output wma_pkg::out_req_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [wma_pkg::CFG_W-1:0] cfg_data
);
  import wma_pkg::*;

  wma_cmd_t cmd;
  wma_sts_t sts;

  // sequencer
  wma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ring, sum and divider
  wma_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

>>> src/wma_ctrl.sv
// wma_ctrl: sequencer for one request at a time (read, apply, divide, deliver)
// and the result valid flag
// depends on wma_pkg
module wma_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  wma_pkg::wma_sts_t sts,
  output wma_pkg::wma_cmd_t cmd
);
  import wma_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // output register can take a new result this cycle
  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (sts.div_last) state_nxt = ST_DONE;
      ST_DONE:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cfg_ready    = 1'b1;
        cmd.take_in  = in_valid;
        cmd.cfg_wr   = cfg_valid;
      end
      ST_READ:   cmd.mem_rd   = 1'b1;
      ST_APPLY:  cmd.apply    = 1'b1;
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_DONE:   cmd.out_load = slot_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/wma_datapath.sv
// wma_datapath: sample ring memory, running sum, fill count, write index,
// window register, radix-2 mean divider and result register
// depends on wma_pkg
module wma_datapath #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wma_pkg::wma_cmd_t           cmd,
  output wma_pkg::wma_sts_t           sts,
  input  wma_pkg::in_req_t            in_data,
  input  logic [wma_pkg::CFG_W-1:0]   cfg_data,
  output wma_pkg::out_req_t           out_data
);
  import wma_pkg::*;

  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int IW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW  = $clog2(((1 << SAMPLE_W) - 1) * MAX_WINDOW + 1);
  localparam int XW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int SCW = $clog2(MEAN_W);

  // sample ring
  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];

  logic [CFG_W-1:0]    window_r;
  logic [SW-1:0]       sum_r;
  logic [CW-1:0]       fill_r;
  logic [IW-1:0]       widx_r;
  logic                mode_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SW-1:0]       rem_r;
  logic [MEAN_W-1:0]   quot_r;
  logic [SCW-1:0]      step_r;
  logic                wrap_r;
  out_req_t            out_data_r;

  logic [CW-1:0]       win_eff;
  logic [CW-1:0]       idx_cur;
  logic [CW-1:0]       upd_idx;
  logic [CW-1:0]       next_idx;
  logic                full;
  logic                is_add;
  logic                wraps;
  logic [IW-1:0]       addr;
  logic [SAMPLE_W-1:0] old_val;
  logic [SW-1:0]       sum_nxt;
  logic [CW-1:0]       fill_nxt;
  logic [IW-1:0]       widx_nxt;
  logic [SW-1:0]       div_trial;
  logic                div_fit;

  // effective window: zero acts as one, clamp to store depth
  always_comb begin
    if (window_r == '0) begin
      win_eff = CW'(1);
    end else if (XW'(window_r) > XW'(MAX_WINDOW)) begin
      win_eff = CW'(MAX_WINDOW);
    end else begin
      win_eff = CW'(window_r);
    end
  end

  // ring position and update decision
  always_comb begin
    idx_cur  = (CW'(widx_r) >= win_eff) ? '0 : CW'(widx_r);
    full     = fill_r >= win_eff;
    is_add   = (mode_r == MODE_ADD) || (fill_r == '0);
    upd_idx  = (idx_cur == '0) ? (win_eff - CW'(1)) : (idx_cur - CW'(1));
    next_idx = idx_cur + CW'(1);
    wraps    = next_idx >= win_eff;
    addr     = is_add ? IW'(idx_cur) : IW'(upd_idx);
  end

  // new sum, count and index
  always_comb begin
    old_val  = (is_add && !full) ? '0 : rd_data_r;
    sum_nxt  = sum_r - SW'(old_val) + SW'(sample_r);
    fill_nxt = fill_r;
    widx_nxt = widx_r;
    if (is_add) begin
      fill_nxt = full ? win_eff : (fill_r + CW'(1));
      widx_nxt = wraps ? '0 : IW'(next_idx);
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_data_r <= mem[addr];
    end
    if (cmd.apply) begin
      mem[addr] <= sample_r;
    end
  end

  // control state of the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      sum_r    <= '0;
      fill_r   <= '0;
      widx_r   <= '0;
    end else if (cmd.cfg_wr) begin
      window_r <= cfg_data;
      sum_r    <= '0;
      fill_r   <= '0;
      widx_r   <= '0;
    end else if (cmd.apply) begin
      sum_r    <= sum_nxt;
      fill_r   <= fill_nxt;
      widx_r   <= widx_nxt;
    end
  end

  // captured request
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      mode_r   <= in_data.mode;
      sample_r <= in_data.sample;
    end
  end

  // restoring divider, one quotient bit per cycle, msb first
  assign div_trial = SW'(fill_r) << step_r;
  assign div_fit   = rem_r >= div_trial;

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rem_r  <= sum_nxt;
      quot_r <= '0;
      step_r <= SCW'(MEAN_W - 1);
      wrap_r <= is_add && wraps;
    end else if (cmd.div_step) begin
      if (div_fit) begin
        rem_r <= rem_r - div_trial;
      end
      quot_r <= {quot_r[MEAN_W-2:0], div_fit};
      step_r <= step_r - SCW'(1);
    end
  end

  assign sts.div_last = (step_r == '0);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.mean           <= quot_r;
      out_data_r.cycle_complete <= wrap_r;
    end
  end

  assign out_data = out_data_r;

endmodule
